>>> rtl/dc16_pkg.sv
// Package with the word types, constants and CRC functions of the dual CRC-16 check.
package dc16_pkg;

  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [15:0] reference_crc;
  } dc16_in_t;

  typedef struct packed {
    logic [15:0] crc_msb_first;
    logic [15:0] crc_reflected;
    logic        ref_hit;
  } dc16_out_t;

  function automatic logic [7:0] rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7 - i];
    end
    return r;
  endfunction

  function automatic logic [15:0] rev16(input logic [15:0] v);
    return {rev8(v[7:0]), rev8(v[15:8])};
  endfunction

  // Eight MSB-first steps of the polynomial division, one per data bit.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

endpackage

>>> rtl/dc16_crc_core.sv
// Running CRC registers of both forms and the result logic for the final byte.
module dc16_crc_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  dc16_pkg::dc16_in_t  item,
  output dc16_pkg::dc16_out_t result
);
  import dc16_pkg::*;

  logic [15:0] crc_norm_r, crc_norm_nxt;
  logic [15:0] crc_rev_r, crc_rev_nxt;
  logic [15:0] norm_upd, rev_upd, refl;

  always_comb begin
    norm_upd = crc_feed(crc_norm_r, item.data_byte);
    rev_upd  = crc_feed(crc_rev_r, rev8(item.data_byte));
    refl     = rev16(rev_upd);

    result.crc_msb_first = norm_upd;
    result.crc_reflected = refl;
    result.ref_hit       = (norm_upd == item.reference_crc) || (refl == item.reference_crc);

    crc_norm_nxt = crc_norm_r;
    crc_rev_nxt  = crc_rev_r;
    if (step) begin
      crc_norm_nxt = item.last_byte ? CRC_INIT : norm_upd;
      crc_rev_nxt  = item.last_byte ? CRC_INIT : rev_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_norm_r <= CRC_INIT;
      crc_rev_r  <= CRC_INIT;
    end else begin
      crc_norm_r <= crc_norm_nxt;
      crc_rev_r  <= crc_rev_nxt;
    end
  end

endmodule

>>> rtl/dual_crc16_check_top.sv
// Top level of the dual CRC-16 check: input register, CRC core and result register.
// An accepted word is held in the input register, where the CRC logic works on it, and the result
// word of a final byte is written to the output register when that byte leaves the input register.
// One word is taken every cycle; the input stalls only while a result word waits
// for the consumer and the byte held in the input register is marked last.
// Synchronous active-low reset empties both registers and clears both running CRCs.
module dual_crc16_check_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dc16_pkg::dc16_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output dc16_pkg::dc16_out_t out_data
);
  import dc16_pkg::*;

  logic      s1_valid_r, s1_valid_nxt;
  dc16_in_t  s1_data_r;
  logic      out_valid_r, out_valid_nxt;
  dc16_out_t out_data_r;
  dc16_out_t core_res;
  logic      out_free, advance;

  assign out_free = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && (!s1_data_r.last_byte || out_free);
  assign in_ready = !s1_valid_r || advance;

  dc16_crc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .item   (s1_data_r),
    .result (core_res)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (advance && s1_data_r.last_byte) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (advance && s1_data_r.last_byte) begin
      out_data_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/dc16_checker.sv
// Port-level checker of the dual CRC-16 check and its binding to the top level.
module dc16_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input dc16_pkg::dc16_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input dc16_pkg::dc16_out_t out_data
);
  import dc16_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Result word changed or vanished while stalled.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result word valid straight after reset.");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("Input stalled without a waiting result word.");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_data.last_byte, 2))
    else $error("Result word appeared without a final byte two cycles earlier.");

endmodule

bind dual_crc16_check_top dc16_checker u_dc16_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

>>> tb/dual_crc16_check_top_tb.sv
// Self-checking testbench for the dual CRC-16 check, with byte messages against a running CRC predictor.
module dual_crc16_check_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dc16_pkg::*;

  localparam logic [15:0] GEN_POLY    = 16'h8005;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          WORD_TARGET = 450;

  typedef enum int {REF_RANDOM, REF_NORMAL, REF_REFLECTED, REF_ZERO, REF_ONES} ref_choice_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  dc16_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  dc16_out_t out_data;

  dc16_in_t  pending_words[$];
  dc16_out_t crc_expected[$];
  int        drain_points[$];

  logic [15:0] gen_normal = '0;
  logic [15:0] gen_reflected = '0;
  logic [15:0] run_normal = '0;
  logic [15:0] run_reflected = '0;

  bit in_taken = 1'b0;
  int words_sent = 0;
  int burst_left = 8;
  int gap_left = 0;
  int rx_mode = 0;
  int cycle_count = 0;
  int fail_count = 0;

  dual_crc16_check_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] mirror8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = v[7 - i];
    return r;
  endfunction

  function automatic logic [15:0] mirror16(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) r[i] = v[15 - i];
    return r;
  endfunction

  function automatic logic [15:0] divide_octet(input logic [15:0] crc, input logic [7:0] octet);
    logic [15:0] acc;
    logic        carry;
    acc = crc;
    for (int i = 7; i >= 0; i--) begin
      carry = acc[15] ^ octet[i];
      acc   = {acc[14:0], 1'b0};
      if (carry) acc = acc ^ GEN_POLY;
    end
    return acc;
  endfunction

  // Builds one message word; a last word's reference is a message CRC, zero, all ones or random.
  task automatic queue_byte(input logic [7:0] octet, input bit is_last, input ref_choice_t choice);
    dc16_in_t    w;
    logic [15:0] arc_value;
    gen_normal    = divide_octet(gen_normal, octet);
    gen_reflected = divide_octet(gen_reflected, mirror8(octet));
    arc_value     = mirror16(gen_reflected);
    w.data_byte     = octet;
    w.last_byte     = is_last;
    w.reference_crc = 16'($urandom);
    if (is_last) begin
      case (choice)
        REF_NORMAL:    w.reference_crc = gen_normal;
        REF_REFLECTED: w.reference_crc = arc_value;
        REF_ZERO:      w.reference_crc = 16'h0000;
        REF_ONES:      w.reference_crc = 16'hFFFF;
        default:       w.reference_crc = 16'($urandom);
      endcase
      gen_normal    = '0;
      gen_reflected = '0;
    end
    pending_words.push_back(w);
  endtask

  task automatic queue_message(input int len, input ref_choice_t choice);
    logic [7:0] octet;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       octet = 8'h00;
        1:       octet = 8'hFF;
        default: octet = 8'($urandom);
      endcase
      queue_byte(octet, i == len - 1, choice);
    end
  endtask

  task automatic absorb_word(input dc16_in_t w);
    dc16_out_t res;
    run_normal    = divide_octet(run_normal, w.data_byte);
    run_reflected = divide_octet(run_reflected, mirror8(w.data_byte));
    if (w.last_byte) begin
      res.crc_msb_first = run_normal;
      res.crc_reflected = mirror16(run_reflected);
      res.ref_hit       = (res.crc_msb_first == w.reference_crc) ||
                          (res.crc_reflected == w.reference_crc);
      crc_expected.push_back(res);
      run_normal    = '0;
      run_reflected = '0;
    end
  endtask

  initial begin
    string       check_text;
    ref_choice_t choice;
    int          len;
    check_text = "123456789";
    queue_byte(8'h00, 1'b1, REF_ZERO);
    queue_byte(8'hFF, 1'b1, REF_ONES);
    queue_byte(8'hFF, 1'b1, REF_NORMAL);
    queue_byte(8'h80, 1'b1, REF_REFLECTED);
    for (int i = 0; i < check_text.len(); i++) begin
      queue_byte(8'(check_text[i]), i == check_text.len() - 1, REF_REFLECTED);
    end
    queue_byte(8'h01, 1'b0, REF_RANDOM);
    queue_byte(8'h80, 1'b1, REF_NORMAL);
    queue_byte(8'hFF, 1'b0, REF_RANDOM);
    queue_byte(8'h00, 1'b0, REF_RANDOM);
    queue_byte(8'hA5, 1'b1, REF_RANDOM);
    queue_byte(8'h5A, 1'b0, REF_RANDOM);
    queue_byte(8'h3C, 1'b1, REF_ONES);
    drain_points.push_back(pending_words.size());

    while (pending_words.size() < WORD_TARGET) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
      case ($urandom_range(0, 9))
        0, 1, 2: choice = REF_NORMAL;
        3, 4, 5: choice = REF_REFLECTED;
        6:       choice = REF_ZERO;
        7:       choice = REF_ONES;
        default: choice = REF_RANDOM;
      endcase
      queue_message(len, choice);
      if (drain_points.size() == 1 && pending_words.size() > WORD_TARGET / 2) begin
        drain_points.push_back(pending_words.size());
      end
    end

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    while (pending_words.size() > 0 || in_valid) @(posedge clk);
    while (crc_expected.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (drain_points.size() > 0 && words_sent == drain_points[0]) begin
        in_valid <= 1'b0;
        if (crc_expected.size() == 0) void'(drain_points.pop_front());
      end else if (pending_words.size() > 0) begin
        in_data  <= pending_words.pop_front();
        in_valid <= 1'b1;
        words_sent++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
    in_taken = 1'b0;
  end

  always @(negedge clk) begin
    if (cycle_count % 64 == 0) rx_mode = $urandom_range(0, 3);
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= $urandom_range(0, 1);
      2:       out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (cycle_count % 5 != 0);
    endcase
  end

  always @(posedge clk) begin
    dc16_out_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        absorb_word(in_data);
      end
      if (out_valid && out_ready) begin
        if (crc_expected.size() == 0) begin
          $error("Result word arrived with none expected: %h", out_data);
          fail_count++;
        end else begin
          want = crc_expected.pop_front();
          if (out_data.crc_msb_first !== want.crc_msb_first) begin
            $error("crc_msb_first: expected %h, got %h", want.crc_msb_first,
                   out_data.crc_msb_first);
            fail_count++;
          end
          if (out_data.crc_reflected !== want.crc_reflected) begin
            $error("crc_reflected: expected %h, got %h", want.crc_reflected,
                   out_data.crc_reflected);
            fail_count++;
          end
          if (out_data.ref_hit !== want.ref_hit) begin
            $error("ref_hit: expected %b, got %b", want.ref_hit, out_data.ref_hit);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule

>>> filelist.f
rtl/dc16_pkg.sv
rtl/dc16_crc_core.sv
rtl/dual_crc16_check_top.sv
rtl/dc16_checker.sv
tb/dual_crc16_check_top_tb.sv
